@@ rtl/core/pwa_pkg.sv @@
// shared types, codes and field layout for the two-level page walk access unit
package pwa_pkg;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 104;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGING_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_DIR_BASE = 1'b1;

    // input opcodes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_REPLY   = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_DIR_READ   = 2'd0;
    localparam logic [1:0] KIND_TABLE_READ = 2'd1;
    localparam logic [1:0] KIND_PHYS       = 2'd2;
    localparam logic [1:0] KIND_READ_VALUE = 2'd3;

    // fault codes
    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_PDE_ABSENT = 2'd1;
    localparam logic [1:0] FAULT_WR_CROSS  = 2'd2;

    // access lengths
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // walk phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_PDE  = 4'b0010,
        PH_PTE  = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    // one input transaction
    typedef struct packed {
        logic        opcode;
        logic [31:0] vaddr;
        logic [2:0]  access_len;
        logic        is_write;
        logic [31:0] write_data;
        logic [31:0] reply_data;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] mem_addr;
        logic [2:0]  mem_len;
        logic        mem_write;
        logic [31:0] mem_wdata;
        logic [31:0] read_value;
        logic [1:0]  fault;
        logic        last;
    } result_t;

    // handshake between the stages
    typedef struct packed {
        logic step;      // input register hands its item to the walk logic
    } flow_t;

endpackage

@@ rtl/core/pwa_in_stage.sv @@
// input register: captures a stream transaction and unpacks its fields
module pwa_in_stage
    import pwa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  flow_t                flow,
    output logic                 item_valid,
    output item_t                item
);

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t item_reg;

    // accept when empty or when the held item moves on this cycle
    assign s_tready = !in_valid_reg || flow.step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (flow.step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.opcode     <= s_tuser;
            item_reg.vaddr      <= s_tdata[31:0];
            item_reg.access_len <= s_tdata[34:32];
            item_reg.is_write   <= s_tdata[35];
            item_reg.write_data <= s_tdata[67:36];
            item_reg.reply_data <= s_tdata[99:68];
        end
    end

    assign item_valid = in_valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/core/pwa_walk.sv @@
// walk state, configuration registers and the per-transaction translation step
module pwa_walk
    import pwa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  step,
    input  item_t                 item,
    output logic                  res_valid,
    output result_t               res
);

    logic        paging_enable_reg;
    logic [19:0] page_dir_base_reg;

    phase_t      phase_reg,           phase_next;
    logic [31:0] current_address_reg, current_address_next;
    logic [2:0]  request_length_reg,  request_length_next;
    logic [1:0]  byte_index_reg,      byte_index_next;
    logic        split_mode_reg,      split_mode_next;
    logic        write_pending_reg,   write_pending_next;
    logic [31:0] held_write_data_reg, held_write_data_next;
    logic [31:0] gathered_value_reg,  gathered_value_next;

    logic [2:0]  req_len;
    logic [31:0] end_addr;
    logic        crosses;
    logic        xl_go;
    logic        phys_go;
    logic [31:0] phys_addr;
    logic [31:0] gathered_merge;
    logic [31:0] direct_value;
    logic        last_byte;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_enable_reg <= 1'b0;
            page_dir_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAGING_ENABLE: paging_enable_reg <= cfg_wdata[0];
                CFG_PAGE_DIR_BASE: page_dir_base_reg <= cfg_wdata;
                default:           paging_enable_reg <= paging_enable_reg;
            endcase
        end
    end

    // request length clamp and page crossing check
    always_comb
    begin
        req_len = item.access_len;
        if (item.access_len == 3'd0)
        begin
            req_len = LEN_ONE;
        end
        else if (item.access_len > LEN_FOUR)
        begin
            req_len = LEN_FOUR;
        end
        end_addr = item.vaddr + {29'd0, req_len} - 32'd1;
        crosses  = item.vaddr[31:12] != end_addr[31:12];
    end

    // byte gather and masked direct read value
    always_comb
    begin
        gathered_merge = gathered_value_reg;
        case (byte_index_reg)
            2'd0:    gathered_merge[7:0]   = gathered_value_reg[7:0]   | item.reply_data[7:0];
            2'd1:    gathered_merge[15:8]  = gathered_value_reg[15:8]  | item.reply_data[7:0];
            2'd2:    gathered_merge[23:16] = gathered_value_reg[23:16] | item.reply_data[7:0];
            default: gathered_merge[31:24] = gathered_value_reg[31:24] | item.reply_data[7:0];
        endcase
        case (request_length_reg)
            3'd1:    direct_value = {24'd0, item.reply_data[7:0]};
            3'd2:    direct_value = {16'd0, item.reply_data[15:0]};
            3'd3:    direct_value = {8'd0, item.reply_data[23:0]};
            default: direct_value = item.reply_data;
        endcase
        last_byte = ({1'b0, byte_index_reg} + 3'd1) >= request_length_reg;
    end

    // next state and result for one transaction
    always_comb
    begin
        phase_next           = phase_reg;
        current_address_next = current_address_reg;
        request_length_next  = request_length_reg;
        byte_index_next      = byte_index_reg;
        split_mode_next      = split_mode_reg;
        write_pending_next   = write_pending_reg;
        held_write_data_next = held_write_data_reg;
        gathered_value_next  = gathered_value_reg;
        res_valid            = 1'b0;
        res                  = '0;
        xl_go                = 1'b0;
        phys_go              = 1'b0;
        phys_addr            = current_address_reg;

        if (item.opcode == OP_REQUEST)
        begin
            if (phase_reg == PH_IDLE)
            begin
                current_address_next = item.vaddr;
                request_length_next  = req_len;
                byte_index_next      = 2'd0;
                gathered_value_next  = '0;
                held_write_data_next = item.write_data;
                res_valid            = 1'b1;
                if (crosses && item.is_write)
                begin
                    // write across a page boundary
                    split_mode_next    = 1'b0;
                    write_pending_next = 1'b0;
                    res.result_kind    = KIND_PHYS;
                    res.fault          = FAULT_WR_CROSS;
                    res.last           = 1'b1;
                end
                else
                begin
                    split_mode_next    = crosses;
                    write_pending_next = item.is_write;
                    xl_go              = 1'b1;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_PDE:
                begin
                    res_valid = 1'b1;
                    if (!item.reply_data[0])
                    begin
                        res.result_kind = KIND_PHYS;
                        res.fault       = FAULT_PDE_ABSENT;
                        res.last        = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        res.result_kind = KIND_TABLE_READ;
                        res.mem_addr    = {item.reply_data[31:12],
                                           current_address_reg[21:12], 2'b00};
                        res.mem_len     = LEN_FOUR;
                        phase_next      = PH_PTE;
                    end
                end
                PH_PTE:
                begin
                    res_valid = 1'b1;
                    phys_go   = 1'b1;
                    phys_addr = {item.reply_data[31:12], current_address_reg[11:0]};
                end
                PH_DATA:
                begin
                    res_valid = 1'b1;
                    if (!split_mode_reg)
                    begin
                        res.result_kind = KIND_READ_VALUE;
                        res.read_value  = direct_value;
                        res.last        = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        gathered_value_next = gathered_merge;
                        if (last_byte)
                        begin
                            res.result_kind = KIND_READ_VALUE;
                            res.read_value  = gathered_merge;
                            res.last        = 1'b1;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            // next byte of a split read
                            byte_index_next      = byte_index_reg + 2'd1;
                            current_address_next = current_address_reg + 32'd1;
                            xl_go                = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end

        // start a translation of the updated address
        if (xl_go)
        begin
            if (paging_enable_reg)
            begin
                res.result_kind = KIND_DIR_READ;
                res.mem_addr    = {page_dir_base_reg, current_address_next[31:22], 2'b00};
                res.mem_len     = LEN_FOUR;
                phase_next      = PH_PDE;
            end
            else
            begin
                phys_go   = 1'b1;
                phys_addr = current_address_next;
            end
        end

        // physical access
        if (phys_go)
        begin
            res.result_kind = KIND_PHYS;
            res.mem_addr    = phys_addr;
            res.mem_len     = split_mode_next ? LEN_ONE : request_length_next;
            if (write_pending_next)
            begin
                res.mem_write = 1'b1;
                res.mem_wdata = held_write_data_next;
                res.last      = 1'b1;
                phase_next    = PH_IDLE;
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            current_address_reg <= '0;
            request_length_reg  <= '0;
            byte_index_reg      <= '0;
            split_mode_reg      <= 1'b0;
            write_pending_reg   <= 1'b0;
            held_write_data_reg <= '0;
            gathered_value_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            current_address_reg <= current_address_next;
            request_length_reg  <= request_length_next;
            byte_index_reg      <= byte_index_next;
            split_mode_reg      <= split_mode_next;
            write_pending_reg   <= write_pending_next;
            held_write_data_reg <= held_write_data_next;
            gathered_value_reg  <= gathered_value_next;
        end
    end

endmodule

@@ rtl/core/pwa_out_stage.sv @@
// result register: holds one result transaction until the sink takes it
module pwa_out_stage
    import pwa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  result_t               res,
    output logic                  out_space,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    // free when empty or drained this cycle
    assign out_space = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    // pack the stream bus
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.result_kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {2'b00, res_reg.fault, res_reg.read_value, res_reg.mem_wdata,
                       res_reg.mem_write, res_reg.mem_len, res_reg.mem_addr};

endmodule

@@ rtl/core/two_level_page_walk_access.sv @@
// top level of the two-level page walk access unit
// A request (tuser 0) or a memory reply (tuser 1) is taken every cycle while the
// result register has room, and each gives at most one result: it passes through
// the input register and then the result register, with the whole walk step done
// by the logic between them. With paging on, a request first asks for the
// directory entry at {page_dir_base, dir, 00}, its reply, if that entry is present,
// asks for the table entry, and that reply yields the physical access; a read
// crossing a 4 KiB page goes one byte at a time and ends with an assembled read
// value. A new request while a walk is open, or a reply while idle, is consumed
// with no result. Write configuration only while no transaction is in flight.
module two_level_page_walk_access
    import pwa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request and reply stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // vaddr, access_len, is_write, write_data, reply_data
    input  logic                  s_tuser,  // opcode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // mem_addr, mem_len, mem_write, mem_wdata,
                                            // read_value, fault
    output logic [1:0]            m_tuser,  // result_kind
    output logic                  m_tlast,  // last
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    flow_t   flow;
    logic    item_valid;
    item_t   item;
    logic    res_valid;
    result_t res;
    logic    out_space;

    // advance the held transaction when the result register has room
    assign flow.step      = item_valid && out_space;

    pwa_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .flow       (flow),
        .item_valid (item_valid),
        .item       (item)
    );

    pwa_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (flow.step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    pwa_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (flow.step && res_valid),
        .res       (res),
        .out_space (out_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
